// ----- sv/htp_pkg.sv -----
package htp_pkg;

  // field limits, a byte at position limit or beyond is dropped
  localparam int unsigned METHOD_LIMIT = 32;
  localparam int unsigned HOST_LIMIT   = 512;
  localparam int unsigned PORT_LIMIT   = 6;
  localparam int unsigned URI_LIMIT    = 4096;

  // counters hold the limit itself, so one bit more than the positions
  localparam int unsigned MIDX_W = $clog2(METHOD_LIMIT + 1);
  localparam int unsigned FIDX_W = $clog2(URI_LIMIT + 1);
  localparam int unsigned POS_W  = 12;

  // result slots of one request byte, emitted lowest first
  localparam int unsigned NSLOT  = 8;
  localparam int unsigned SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_METHOD = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_URL    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_MK1    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_MK2    = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_MK3    = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_P8     = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_P0     = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_STAT   = 3'd7;

  // queue between front and back end
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // characters
  localparam logic [7:0]  CH_SP    = 8'h20;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_W     = 8'h77;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_8     = 8'h38;
  localparam logic [7:0]  CH_0     = 8'h30;
  localparam logic [31:0] END_SEQ  = 32'h0D0A0D0A;

  typedef enum logic [2:0] {
    KIND_METHOD = 3'd0,
    KIND_HOST   = 3'd1,
    KIND_PORT   = 3'd2,
    KIND_URI    = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_HOST   = 5'b00010,
    PH_PORT   = 5'b00100,
    PH_URI    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  // classified request byte, one entry per byte that causes results
  typedef struct packed {
    logic [NSLOT-1:0]  mask;
    logic [7:0]        chr;
    logic [MIDX_W-1:0] m_pos;
    logic              marker;
    kind_e             u_kind;
    logic [POS_W-1:0]  u_pos;
    logic              complete;
    logic              host_found;
    logic              overflow;
  } htp_op_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       chr;
    logic [POS_W-1:0] pos;
    logic             complete;
    logic             host_found;
    logic             overflow;
    logic             run_end;
  } htp_res_t;

endpackage

// ----- sv/htp_front.sv -----
module htp_front
  import htp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic    in_last_i,
  input  logic    q_full_i,
  output logic    push_o,
  output htp_op_t op_o
);

  localparam logic [MIDX_W-1:0] M_LIM    = MIDX_W'(METHOD_LIMIT);
  localparam logic [FIDX_W-1:0] HOST_LIM = FIDX_W'(HOST_LIMIT);
  localparam logic [FIDX_W-1:0] PORT_LIM = FIDX_W'(PORT_LIMIT);
  localparam logic [FIDX_W-1:0] URI_LIM  = FIDX_W'(URI_LIMIT);
  localparam logic [FIDX_W-1:0] MK_LEN   = FIDX_W'(4);
  localparam logic [2:0]        SEEN_MAX = 3'd4;

  logic              m_act_q, m_act_d;
  phase_e            phase_q, phase_d;
  logic [1:0]        mk_q, mk_d;
  logic [31:0]       recent_q, recent_d;
  logic [2:0]        seen_q, seen_d;
  logic [MIDX_W-1:0] midx_q, midx_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;
  logic              pg_q, pg_d;
  logic              ovf_q, ovf_d;

  logic              acc;
  logic              c_req;
  kind_e             c_kind;
  logic [FIDX_W-1:0] c_idx;
  logic [FIDX_W-1:0] c_lim;
  htp_op_t           op;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  // classify one byte and compute the next parser state
  always_comb begin
    m_act_d  = m_act_q;
    phase_d  = phase_q;
    mk_d     = mk_q;
    midx_d   = midx_q;
    fidx_d   = fidx_q;
    pg_d     = pg_q;
    ovf_d    = ovf_q;
    recent_d = {recent_q[23:0], in_byte_i};
    seen_d   = (seen_q == SEEN_MAX) ? seen_q : seen_q + 3'd1;
    c_req    = 1'b0;
    c_kind   = KIND_URI;
    c_idx    = fidx_q;
    c_lim    = URI_LIM;
    op       = '0;
    op.chr   = in_byte_i;
    op.u_kind = KIND_URI;

    // method part, up to the first space
    if (m_act_q) begin
      if (in_byte_i == CH_SP) begin
        m_act_d = 1'b0;
      end else if (midx_q < M_LIM) begin
        op.mask[SLOT_METHOD] = 1'b1;
        op.m_pos = midx_q;
        midx_d = midx_q + MIDX_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    // host, port and uri part
    case (phase_q)
      PH_SEARCH: begin
        if (mk_q == 2'd3 && in_byte_i == CH_DOT) begin
          op.mask[SLOT_URL] = 1'b1;
          op.mask[SLOT_MK1] = 1'b1;
          op.mask[SLOT_MK2] = 1'b1;
          op.mask[SLOT_MK3] = 1'b1;
          op.marker = 1'b1;
          fidx_d = MK_LEN;
          phase_d = PH_HOST;
          mk_d = 2'd0;
        end else if (in_byte_i == CH_W) begin
          if (mk_q != 2'd3) mk_d = mk_q + 2'd1;
        end else begin
          mk_d = 2'd0;
        end
      end
      PH_HOST: begin
        if (in_byte_i == CH_COLON) begin
          phase_d = PH_PORT;
          pg_d = 1'b1;
          fidx_d = '0;
        end else if (in_byte_i == CH_SLASH) begin
          phase_d = PH_URI;
          c_req = 1'b1;
          c_idx = '0;
        end else begin
          c_req = 1'b1;
          c_kind = KIND_HOST;
          c_lim = HOST_LIM;
        end
      end
      PH_PORT: begin
        if (in_byte_i == CH_SLASH) begin
          phase_d = PH_URI;
          c_req = 1'b1;
          c_idx = '0;
        end else begin
          c_req = 1'b1;
          c_kind = KIND_PORT;
          c_lim = PORT_LIM;
        end
      end
      PH_URI: begin
        if (in_byte_i == CH_SP) begin
          phase_d = PH_DONE;
        end else begin
          c_req = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // one field character, dropped past its limit
    if (c_req) begin
      fidx_d = c_idx;
      if (c_idx < c_lim) begin
        op.mask[SLOT_URL] = 1'b1;
        op.u_kind = c_kind;
        op.u_pos = c_idx[POS_W-1:0];
        fidx_d = c_idx + FIDX_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    // end of request: default port, status, then back to reset state
    if (in_last_i) begin
      op.complete = (seen_d == SEEN_MAX) && (recent_d == END_SEQ);
      op.host_found = (phase_d != PH_SEARCH);
      op.overflow = ovf_d;
      op.mask[SLOT_P8] = !pg_d;
      op.mask[SLOT_P0] = !pg_d;
      op.mask[SLOT_STAT] = 1'b1;
      m_act_d  = 1'b1;
      phase_d  = PH_SEARCH;
      mk_d     = '0;
      recent_d = '0;
      seen_d   = '0;
      midx_d   = '0;
      fidx_d   = '0;
      pg_d     = 1'b0;
      ovf_d    = 1'b0;
    end
  end

  assign push_o = acc && (op.mask != '0);
  assign op_o   = op;

  // parser state, advances on each accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_act_q  <= 1'b1;
      phase_q  <= PH_SEARCH;
      mk_q     <= '0;
      recent_q <= '0;
      seen_q   <= '0;
      midx_q   <= '0;
      fidx_q   <= '0;
      pg_q     <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (acc) begin
      m_act_q  <= m_act_d;
      phase_q  <= phase_d;
      mk_q     <= mk_d;
      recent_q <= recent_d;
      seen_q   <= seen_d;
      midx_q   <= midx_d;
      fidx_q   <= fidx_d;
      pg_q     <= pg_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// ----- sv/htp_fifo.sv -----
module htp_fifo
  import htp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  htp_op_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output htp_op_t data_o
);

  localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W + 1)'(QDEPTH);

  htp_op_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QPTR_W:0]    cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QPTR_W'(1);
      if (pop_i) rptr_q <= rptr_q + QPTR_W'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CNT_FULL))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");
`endif

endmodule

// ----- sv/htp_back.sv -----
module htp_back
  import htp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  htp_op_t  q_op_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output htp_res_t res_o
);

  logic              cur_vld_q;
  htp_op_t           cur_q;
  logic [NSLOT-1:0]  mask_q;
  logic              out_vld_q;
  htp_res_t          res_q;

  logic              emit;
  logic              load;
  logic [NSLOT-1:0]  rem;
  logic [SLOT_W-1:0] sel;
  htp_res_t          res_d;

  // lowest pending slot goes next
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = SLOT_W'(i);
    end
  end

  assign rem   = mask_q & (mask_q - NSLOT'(1));
  assign emit  = cur_vld_q && (!out_vld_q || out_ready_i);
  assign load  = q_valid_i && (!cur_vld_q || (emit && rem == '0));
  assign pop_o = load;

  // build the result of the selected slot
  always_comb begin
    res_d = '0;
    res_d.run_end = (rem == '0);
    case (sel)
      SLOT_METHOD: begin
        res_d.kind = KIND_METHOD;
        res_d.chr  = cur_q.chr;
        res_d.pos  = POS_W'(cur_q.m_pos);
      end
      SLOT_URL: begin
        if (cur_q.marker) begin
          res_d.kind = KIND_HOST;
          res_d.chr  = CH_W;
          res_d.pos  = POS_W'(0);
        end else begin
          res_d.kind = cur_q.u_kind;
          res_d.chr  = cur_q.chr;
          res_d.pos  = cur_q.u_pos;
        end
      end
      SLOT_MK1: begin
        res_d.kind = KIND_HOST;
        res_d.chr  = CH_W;
        res_d.pos  = POS_W'(1);
      end
      SLOT_MK2: begin
        res_d.kind = KIND_HOST;
        res_d.chr  = CH_W;
        res_d.pos  = POS_W'(2);
      end
      SLOT_MK3: begin
        res_d.kind = KIND_HOST;
        res_d.chr  = CH_DOT;
        res_d.pos  = POS_W'(3);
      end
      SLOT_P8: begin
        res_d.kind = KIND_PORT;
        res_d.chr  = CH_8;
        res_d.pos  = POS_W'(0);
      end
      SLOT_P0: begin
        res_d.kind = KIND_PORT;
        res_d.chr  = CH_0;
        res_d.pos  = POS_W'(1);
      end
      default: begin
        res_d.kind       = KIND_STATUS;
        res_d.complete   = cur_q.complete;
        res_d.host_found = cur_q.host_found;
        res_d.overflow   = cur_q.overflow;
      end
    endcase
  end

  // current entry and pending slot mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      mask_q    <= '0;
    end else if (load) begin
      cur_vld_q <= 1'b1;
      mask_q    <= q_op_i.mask;
    end else if (emit) begin
      mask_q <= rem;
      if (rem == '0) cur_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_op_i;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_cur_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (mask_q != '0))
    else $error("active entry without pending slots");
  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.kind == KIND_STATUS) |-> res_q.run_end)
    else $error("status result not last of its run");
`endif

endmodule

// ----- sv/http_request_target_parser.sv -----
// Request line parser. Request bytes enter on the s_axis channel, one byte per
// transfer, with tlast on the last byte of a request. Results leave on the
// m_axis channel: tuser gives the kind (method, host, port, uri or status),
// tdata the character, its position in the field and the status flags, and
// tlast marks the last result caused by one request byte.
// A front end classifies each byte and updates the parser state in the cycle
// of its transfer; bytes that cause results are queued (4 entries) for a back
// end that emits one result per cycle, unless the output is held, through an
// output register. Throughput: one byte per cycle while each byte causes at
// most one result; a byte causing n results (up to 8: method character,
// marker, default port and status) holds the back end until all n are
// emitted, and the queue absorbs bursts. When m_axis_tready_i is low the
// output holds, the queue fills and then s_axis_tready_o drops. Reset clears
// the parser state, the queue and the output valid; the block takes bytes in
// the first cycle after reset.
module http_request_target_parser
  import htp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // request_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // character, position, complete, host_found, overflow
  output logic [2:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // run_end
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  htp_op_t  q_in;
  htp_op_t  q_out;
  htp_res_t res;

  htp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .op_o       (q_in)
  );

  htp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  htp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_out),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // pack result fields onto the stream
  assign m_axis_tdata_o = {1'b0, res.overflow, res.host_found, res.complete, res.pos, res.chr};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.run_end;

endmodule
